// ===== src/smdc_pkg.sv =====
// ----------------------------------------------------------------------------
// smdc_pkg
// Shared types and constants for the stereo mixer, dc blocker and resampler.
// ----------------------------------------------------------------------------
package smdc_pkg;

   localparam int IN_WIDTH            = 16;
   localparam int OUT_WIDTH           = 16;
   localparam int LEVEL_WIDTH         = 16;
   localparam int SRATE_WIDTH         = 17;
   localparam int ORATE_WIDTH         = 18;
   localparam int RECIP_WIDTH         = 28;
   localparam int CSR_ADDR_WIDTH      = 5;
   localparam int CSR_DATA_WIDTH      = 32;

   localparam int LANES               = 2;
   localparam int GAIN_FRACTION_BITS  = 12;
   localparam int DC_FRACTION_BITS    = 12;
   localparam int POLE_FRACTION_BITS  = 28;
   localparam int RECIP_FRACTION_BITS = 40;

   localparam int MIX_WIDTH           = 20;
   localparam int DC_WIDTH            = 44;
   localparam int SAMPLE_WIDTH        = 32;
   localparam int REM_WIDTH           = 19;

   localparam int GAIN_PROD_WIDTH     = IN_WIDTH + LEVEL_WIDTH + 1;
   localparam int MIX_SUM_WIDTH       = GAIN_PROD_WIDTH + 1;
   localparam int MASTER_PROD_WIDTH   = MIX_SUM_WIDTH + LEVEL_WIDTH + 1;

   localparam int POLE_WIDTH          = 28;
   localparam int POLE_SPLIT          = 16;
   localparam int POLE_LO_PROD_WIDTH  = POLE_WIDTH + POLE_SPLIT;
   localparam int POLE_HI_PROD_WIDTH  = (DC_WIDTH - POLE_SPLIT) + POLE_WIDTH + 1;
   localparam int DC_SUM_WIDTH        = DC_WIDTH + 2;
   localparam int OUT_SUM_WIDTH       = SAMPLE_WIDTH + 4;

   localparam logic [POLE_WIDTH-1:0] POLE_Q = 28'd268167021;

   localparam logic signed [MASTER_PROD_WIDTH-1:0] MIX_MAX =
      {{(MASTER_PROD_WIDTH-MIX_WIDTH+1){1'b0}}, {(MIX_WIDTH-1){1'b1}}};
   localparam logic signed [MASTER_PROD_WIDTH-1:0] MIX_MIN = ~MIX_MAX;

   localparam logic signed [DC_SUM_WIDTH-1:0] DC_MAX =
      {{(DC_SUM_WIDTH-DC_WIDTH+1){1'b0}}, {(DC_WIDTH-1){1'b1}}};
   localparam logic signed [DC_SUM_WIDTH-1:0] DC_MIN = ~DC_MAX;

   localparam logic signed [OUT_SUM_WIDTH-1:0] OUT_MAX =
      {{(OUT_SUM_WIDTH-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_SUM_WIDTH-1:0] OUT_MIN = ~OUT_MAX;

   typedef enum logic [2:0] {
      CSR_FM_LEVEL,
      CSR_PSG_LEVEL,
      CSR_MASTER_LEVEL,
      CSR_SOURCE_RATE,
      CSR_OUTPUT_RATE,
      CSR_RATE_RECIPROCAL
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0] fm_level;
      logic [LEVEL_WIDTH-1:0] psg_level;
      logic [LEVEL_WIDTH-1:0] master_level;
      logic [SRATE_WIDTH-1:0] source_rate;
      logic [ORATE_WIDTH-1:0] output_rate;
      logic [RECIP_WIDTH-1:0] rate_reciprocal;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fm_level:        16'd8192,
      psg_level:       16'd11100,
      master_level:    16'd4096,
      source_rate:     17'd53267,
      output_rate:     18'd44100,
      rate_reciprocal: 28'd24932236
   };

   typedef enum logic [1:0] {
      FILL_EMPTY,
      FILL_OLDER,
      FILL_PRIMED
   } fill_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX,
      ST_MASTER,
      ST_FILT,
      ST_WEIGHT,
      ST_INTERP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_in;
      logic mix;
      logic master;
      logic filt;
      logic weight;
      logic interp;
      logic emit;
      logic last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic fill_empty;
      logic rem_below;
      logic next_rem_below;
   } dp_status_type;

endpackage

// ===== src/smdc_if.sv =====
// ----------------------------------------------------------------------------
// smdc_if
// Valid/ready channels for source frames and resampled output frames.
// ----------------------------------------------------------------------------
interface smdc_req_if import smdc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [IN_WIDTH-1:0] fm_left;
   logic signed [IN_WIDTH-1:0] fm_right;
   logic signed [IN_WIDTH-1:0] psg_left;
   logic signed [IN_WIDTH-1:0] psg_right;

   modport source (output valid, fm_left, fm_right, psg_left, psg_right, input ready);
   modport sink   (input valid, fm_left, fm_right, psg_left, psg_right, output ready);
endinterface

interface smdc_rsp_if import smdc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [OUT_WIDTH-1:0] out_left;
   logic signed [OUT_WIDTH-1:0] out_right;
   logic                        last_of_run;

   modport source (output valid, out_left, out_right, last_of_run, input ready);
   modport sink   (input valid, out_left, out_right, last_of_run, output ready);
endinterface

// ===== src/smdc_csr.sv =====
// ----------------------------------------------------------------------------
// smdc_csr
// Register file for gains and rate settings behind an apb-style port.
// ----------------------------------------------------------------------------
module smdc_csr import smdc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index    = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:2]);
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_FM_LEVEL:        cfg_in.fm_level        = pwdata[LEVEL_WIDTH-1:0];
            CSR_PSG_LEVEL:       cfg_in.psg_level       = pwdata[LEVEL_WIDTH-1:0];
            CSR_MASTER_LEVEL:    cfg_in.master_level    = pwdata[LEVEL_WIDTH-1:0];
            CSR_SOURCE_RATE:     cfg_in.source_rate     = pwdata[SRATE_WIDTH-1:0];
            CSR_OUTPUT_RATE:     cfg_in.output_rate     = pwdata[ORATE_WIDTH-1:0];
            CSR_RATE_RECIPROCAL: cfg_in.rate_reciprocal = pwdata[RECIP_WIDTH-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_FM_LEVEL:        prdata = CSR_DATA_WIDTH'(cfg_ff.fm_level);
         CSR_PSG_LEVEL:       prdata = CSR_DATA_WIDTH'(cfg_ff.psg_level);
         CSR_MASTER_LEVEL:    prdata = CSR_DATA_WIDTH'(cfg_ff.master_level);
         CSR_SOURCE_RATE:     prdata = CSR_DATA_WIDTH'(cfg_ff.source_rate);
         CSR_OUTPUT_RATE:     prdata = CSR_DATA_WIDTH'(cfg_ff.output_rate);
         CSR_RATE_RECIPROCAL: prdata = CSR_DATA_WIDTH'(cfg_ff.rate_reciprocal);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/smdc_ctrl.sv =====
// ----------------------------------------------------------------------------
// smdc_ctrl
// Sequencer for one source frame: mix, filter, then one output per pass.
// ----------------------------------------------------------------------------
module smdc_ctrl import smdc_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_SOURCE = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int CW = (MAX_OUTPUTS_PER_SOURCE > 1) ? $clog2(MAX_OUTPUTS_PER_SOURCE) : 1;
   localparam logic [CW-1:0] COUNT_LAST = CW'(MAX_OUTPUTS_PER_SOURCE - 1);

   state_type     state_ff;
   state_type     state_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          out_free;
   logic          last_run;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_run  = (count_ff == COUNT_LAST) || !status.next_rem_below;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_MIX;
         ST_MIX:    state_in = ST_MASTER;
         ST_MASTER: state_in = ST_FILT;
         ST_FILT:   state_in = status.fill_empty ? ST_IDLE : ST_WEIGHT;
         ST_WEIGHT: state_in = status.rem_below ? ST_INTERP : ST_IDLE;
         ST_INTERP: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = last_run ? ST_IDLE : ST_WEIGHT;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_ready    = 1'b0;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_MIX:    cmd.mix = 1'b1;
         ST_MASTER: cmd.master = 1'b1;
         ST_FILT: begin
            cmd.filt = 1'b1;
            count_in = '0;
         end
         ST_WEIGHT: cmd.weight = 1'b1;
         ST_INTERP: cmd.interp = 1'b1;
         ST_EMIT: begin
            cmd.emit = out_free;
            cmd.last = last_run;
            if (out_free) begin
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/smdc_datapath.sv =====
// ----------------------------------------------------------------------------
// smdc_datapath
// Two-lane mixer, dc blocker and linear interpolator with remainder tracking.
// ----------------------------------------------------------------------------
module smdc_datapath import smdc_pkg::*; #(
   parameter int WEIGHT_FRACTION_BITS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  ctrl_cmd_type                cmd,
   output dp_status_type               status,
   input  logic signed [IN_WIDTH-1:0]  fm_left,
   input  logic signed [IN_WIDTH-1:0]  fm_right,
   input  logic signed [IN_WIDTH-1:0]  psg_left,
   input  logic signed [IN_WIDTH-1:0]  psg_right,
   output logic signed [OUT_WIDTH-1:0] out_left,
   output logic signed [OUT_WIDTH-1:0] out_right,
   output logic                        last_of_run
);

   localparam int TW       = WEIGHT_FRACTION_BITS + 1;
   localparam int RSHIFT   = RECIP_FRACTION_BITS - WEIGHT_FRACTION_BITS;
   localparam int WPROD_W  = REM_WIDTH + RECIP_WIDTH;
   localparam int DIFF_W   = SAMPLE_WIDTH + 1;
   localparam int IPROD_W  = DIFF_W + TW + 1;
   localparam logic [WPROD_W-1:0] TSAT = WPROD_W'(1) << WEIGHT_FRACTION_BITS;

   // per-lane registers
   logic signed [IN_WIDTH-1:0]           fm_ff      [LANES];
   logic signed [IN_WIDTH-1:0]           psg_ff     [LANES];
   logic signed [GAIN_PROD_WIDTH-1:0]    gfm_ff     [LANES];
   logic signed [GAIN_PROD_WIDTH-1:0]    gpsg_ff    [LANES];
   logic signed [MASTER_PROD_WIDTH-1:0]  mp_ff      [LANES];
   logic [POLE_LO_PROD_WIDTH-1:0]        plo_ff     [LANES];
   logic signed [POLE_HI_PROD_WIDTH-1:0] phi_ff     [LANES];
   logic signed [MIX_WIDTH-1:0]          px_ff      [LANES];
   logic signed [DC_WIDTH-1:0]           py_ff      [LANES];
   logic signed [SAMPLE_WIDTH-1:0]       older_ff   [LANES];
   logic signed [SAMPLE_WIDTH-1:0]       newer_ff   [LANES];
   logic signed [IPROD_W-1:0]            dprod_ff   [LANES];
   logic signed [OUT_WIDTH-1:0]          out_ff     [LANES];

   // per-lane logic
   logic signed [IN_WIDTH-1:0]           fm_sample  [LANES];
   logic signed [IN_WIDTH-1:0]           psg_sample [LANES];
   logic signed [GAIN_PROD_WIDTH-1:0]    gfm_in     [LANES];
   logic signed [GAIN_PROD_WIDTH-1:0]    gpsg_in    [LANES];
   logic signed [MIX_SUM_WIDTH-1:0]      mix_sum    [LANES];
   logic signed [MASTER_PROD_WIDTH-1:0]  mp_in      [LANES];
   logic [POLE_LO_PROD_WIDTH-1:0]        plo_in     [LANES];
   logic signed [POLE_HI_PROD_WIDTH-1:0] phi_in     [LANES];
   logic signed [MASTER_PROD_WIDTH-1:0]  mix_sh     [LANES];
   logic signed [MIX_WIDTH-1:0]          mix_x      [LANES];
   logic signed [POLE_HI_PROD_WIDTH-1:0] pole_mid   [LANES];
   logic signed [POLE_HI_PROD_WIDTH-1:0] pole_fb    [LANES];
   logic signed [DC_SUM_WIDTH-1:0]       x_ext      [LANES];
   logic signed [DC_SUM_WIDTH-1:0]       px_ext     [LANES];
   logic signed [DC_SUM_WIDTH-1:0]       y_raw      [LANES];
   logic signed [DC_SUM_WIDTH-1:0]       y_sat      [LANES];
   logic signed [SAMPLE_WIDTH-1:0]       filt       [LANES];
   logic signed [DIFF_W-1:0]             diff       [LANES];
   logic signed [IPROD_W-1:0]            dprod_in   [LANES];
   logic signed [IPROD_W-1:0]            dprod_sh   [LANES];
   logic signed [OUT_SUM_WIDTH-1:0]      vsum       [LANES];
   logic signed [OUT_WIDTH-1:0]          out_in     [LANES];

   // shared state
   logic [REM_WIDTH-1:0] rem_ff;
   logic [REM_WIDTH-1:0] rem_in;
   logic [REM_WIDTH-1:0] rem_next;
   logic [REM_WIDTH-1:0] orate;
   fill_type             fill_ff;
   fill_type             fill_in;
   logic [TW-1:0]        t_ff;
   logic [TW-1:0]        t_in;
   logic [WPROD_W-1:0]   wprod;
   logic [WPROD_W-1:0]   wshift;
   logic                 last_ff;

   assign fm_sample[0]  = fm_left;
   assign fm_sample[1]  = fm_right;
   assign psg_sample[0] = psg_left;
   assign psg_sample[1] = psg_right;

   assign orate    = REM_WIDTH'(cfg.output_rate);
   assign rem_next = rem_ff + REM_WIDTH'(cfg.source_rate);

   assign status.fill_empty     = (fill_ff == FILL_EMPTY);
   assign status.rem_below      = rem_ff < orate;
   assign status.next_rem_below = rem_next < orate;

   assign out_left    = out_ff[0];
   assign out_right   = out_ff[1];
   assign last_of_run = last_ff;

   // weight from remainder
   always_comb begin
      wprod  = rem_ff * cfg.rate_reciprocal;
      wshift = wprod >> RSHIFT;
      t_in   = (wshift > TSAT) ? TW'(TSAT) : TW'(wshift);
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         gfm_in[i]  = fm_ff[i] * $signed({1'b0, cfg.fm_level});
         gpsg_in[i] = psg_ff[i] * $signed({1'b0, cfg.psg_level});
         plo_in[i]  = POLE_Q * py_ff[i][POLE_SPLIT-1:0];
         phi_in[i]  = $signed(py_ff[i][DC_WIDTH-1:POLE_SPLIT]) * $signed({1'b0, POLE_Q});

         mix_sum[i] = MIX_SUM_WIDTH'(gfm_ff[i]) + MIX_SUM_WIDTH'(gpsg_ff[i]);
         mp_in[i]   = mix_sum[i] * $signed({1'b0, cfg.master_level});

         mix_sh[i] = mp_ff[i] >>> (2 * GAIN_FRACTION_BITS);
         if (mix_sh[i] > MIX_MAX) begin
            mix_x[i] = MIX_MAX[MIX_WIDTH-1:0];
         end else if (mix_sh[i] < MIX_MIN) begin
            mix_x[i] = MIX_MIN[MIX_WIDTH-1:0];
         end else begin
            mix_x[i] = mix_sh[i][MIX_WIDTH-1:0];
         end

         pole_mid[i] = phi_ff[i]
                     + $signed(POLE_HI_PROD_WIDTH'(plo_ff[i] >> POLE_SPLIT));
         pole_fb[i]  = pole_mid[i] >>> (POLE_FRACTION_BITS - POLE_SPLIT);
         x_ext[i]    = DC_SUM_WIDTH'(mix_x[i]);
         px_ext[i]   = DC_SUM_WIDTH'(px_ff[i]);
         y_raw[i]    = ((x_ext[i] - px_ext[i]) <<< DC_FRACTION_BITS)
                     + DC_SUM_WIDTH'(pole_fb[i]);
         if (y_raw[i] > DC_MAX) begin
            y_sat[i] = DC_MAX;
         end else if (y_raw[i] < DC_MIN) begin
            y_sat[i] = DC_MIN;
         end else begin
            y_sat[i] = y_raw[i];
         end
         filt[i] = $signed(y_sat[i][DC_WIDTH-1:DC_FRACTION_BITS]);

         diff[i]     = newer_ff[i] - older_ff[i];
         dprod_in[i] = diff[i] * $signed({1'b0, t_ff});

         dprod_sh[i] = dprod_ff[i] >>> WEIGHT_FRACTION_BITS;
         vsum[i]     = OUT_SUM_WIDTH'(dprod_sh[i]) + OUT_SUM_WIDTH'(older_ff[i]);
         if (vsum[i] > OUT_MAX) begin
            out_in[i] = OUT_MAX[OUT_WIDTH-1:0];
         end else if (vsum[i] < OUT_MIN) begin
            out_in[i] = OUT_MIN[OUT_WIDTH-1:0];
         end else begin
            out_in[i] = vsum[i][OUT_WIDTH-1:0];
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      fill_in = fill_ff;
      if (cmd.filt) begin
         unique case (fill_ff)
            FILL_EMPTY: fill_in = FILL_OLDER;
            FILL_OLDER: begin
               fill_in = FILL_PRIMED;
               rem_in  = '0;
            end
            default: rem_in = (rem_ff >= orate) ? rem_ff - orate : '0;
         endcase
      end else if (cmd.emit) begin
         rem_in = rem_next;
      end
   end

   // datapath pipeline registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (cmd.load_in) begin
            fm_ff[i]  <= fm_sample[i];
            psg_ff[i] <= psg_sample[i];
         end
         if (cmd.mix) begin
            gfm_ff[i]  <= gfm_in[i];
            gpsg_ff[i] <= gpsg_in[i];
            plo_ff[i]  <= plo_in[i];
            phi_ff[i]  <= phi_in[i];
         end
         if (cmd.master) begin
            mp_ff[i] <= mp_in[i];
         end
         if (cmd.interp) begin
            dprod_ff[i] <= dprod_in[i];
         end
         if (cmd.emit) begin
            out_ff[i] <= out_in[i];
         end
      end
      if (cmd.weight) begin
         t_ff <= t_in;
      end
      if (cmd.emit) begin
         last_ff <= cmd.last;
      end
   end

   // filter and interpolation state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            px_ff[i]    <= '0;
            py_ff[i]    <= '0;
            older_ff[i] <= '0;
            newer_ff[i] <= '0;
         end
         rem_ff  <= '0;
         fill_ff <= FILL_EMPTY;
      end else begin
         rem_ff  <= rem_in;
         fill_ff <= fill_in;
         if (cmd.filt) begin
            for (int i = 0; i < LANES; i++) begin
               px_ff[i] <= mix_x[i];
               py_ff[i] <= y_sat[i][DC_WIDTH-1:0];
               unique case (fill_ff)
                  FILL_EMPTY: older_ff[i] <= filt[i];
                  FILL_OLDER: newer_ff[i] <= filt[i];
                  default: begin
                     older_ff[i] <= newer_ff[i];
                     newer_ff[i] <= filt[i];
                  end
               endcase
            end
         end
      end
   end

endmodule

// ===== src/stereo_mix_dc_block_resampler_top.sv =====
// ----------------------------------------------------------------------------
// stereo_mix_dc_block_resampler_top
// Stereo mixer, dc blocker and linear-interpolation rate converter.
// ----------------------------------------------------------------------------
// Each source frame runs through accept, gain and pole multiply, master
// multiply and filter update. After priming, a frame may also cause outputs.
// Each output frame adds a weight multiply, an interpolation multiply and
// an output load. A frame gives at most MAX_OUTPUTS_PER_SOURCE outputs. A
// primed frame with no output still passes the weight step, because the
// remainder is still tested once. The first frame after reset skips the
// weight step. The output register holds the sequence while it is stalled.
// Both lanes step through one shared sequence of registered multiply steps.
// The first frame after reset gives no output, and the second primes the
// interpolator. last_of_run marks the final output frame caused by one
// source frame. Program the registers only while idle.
module stereo_mix_dc_block_resampler_top import smdc_pkg::*; #(
   parameter int MAX_OUTPUTS_PER_SOURCE = 4,
   parameter int WEIGHT_FRACTION_BITS   = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   smdc_req_if.sink                  req_ch,
   smdc_rsp_if.source                rsp_ch,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   smdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   smdc_ctrl #(
      .MAX_OUTPUTS_PER_SOURCE (MAX_OUTPUTS_PER_SOURCE)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smdc_datapath #(
      .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .status      (status),
      .fm_left     (req_ch.fm_left),
      .fm_right    (req_ch.fm_right),
      .psg_left    (req_ch.psg_left),
      .psg_right   (req_ch.psg_right),
      .out_left    (rsp_ch.out_left),
      .out_right   (rsp_ch.out_right),
      .last_of_run (rsp_ch.last_of_run)
   );

endmodule
